>>> sv/ipsd_pkg.sv
package ipsd_pkg;

    // Field widths
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = 40;
    localparam int NORM_W    = 39;
    localparam int FRAC_W    = 16;
    localparam int DIST_W    = 19;

    // Stream packing
    localparam int S_TDATA_W = 112;   // 2 x 16 + 2 x 39 = 110, padded to bytes
    localparam int M_TDATA_W = 24;    // 19-bit distance, padded to bytes
    localparam int M_TUSER_W = 2;

    // Divider: magnitude of the dot sum shifted up by the fraction bits
    localparam int DIV_W     = ACC_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int REM_W     = NORM_W + 1;
    localparam int SUB_W     = REM_W + 1;

    // Norm terms, their product and the square root
    localparam int TERM_W    = FRAC_W + 1;
    localparam int SQ_W      = 2 * TERM_W - 1;
    localparam int SR_W      = SQ_W + 1;

    // Final sum before saturation
    localparam int WIDE_W    = DIV_W + 3;

    localparam logic [TERM_W-1:0] ONE_Q16 = TERM_W'(65536);
    localparam logic signed [WIDE_W-1:0] DIST_MAX = WIDE_W'(131072);
    localparam logic signed [WIDE_W-1:0] DIST_MIN = -WIDE_W'(131072);
    localparam logic [DIST_W-1:0] DIST_POS_CODE = DIST_W'(131072);
    localparam logic [DIST_W-1:0] DIST_NEG_CODE = DIST_W'(393216);

    // Positions in m_tuser
    localparam int USER_BAD_NORM  = 0;
    localparam int USER_SATURATED = 1;

endpackage

>>> sv/inner_product_search_distance_core.sv
// Inner product to distance transform for maximum inner product search.
//
// Input stream (s_t*): one request per vector element pair. s_tdata carries
// elem_a, elem_b, norm_a and norm_b; s_tlast marks the final pair. Products of
// the elements are summed exactly in a 40-bit accumulator. Non-final requests
// are taken one per cycle while the block is idle.
// On the final request the block computes
//   1 - dot/norm_scale - sqrt((1 - norm_a/norm_scale)(1 - norm_b/norm_scale))
// and sends one request on m_t* with the Q2.16 distance in m_tdata and the
// bad_norm and saturated flags in m_tuser. Three 56-step restoring divisions
// (a norm above norm_scale skips its division) and a 17-step square root share
// one compare/subtract unit; the one multiply has its own multiplier.
// After the final request s_tready is low and rises again once the result is
// in the output register. A stalled receiver holds the result there while the
// next vector streams in; a second result waits in the sequencer until the
// first is taken.
// cfg_* writes norm_scale (always ready); write it only while idle.
// Reset (rst_n low, asynchronous) clears the accumulator and sets norm_scale
// to 1. A norm_scale of zero acts as one.
module inner_product_search_distance_core
    import ipsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [NORM_W-1:0]    cfg_data,      // norm_scale
    // element stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // elem_a, elem_b, norm_a, norm_b
    input  logic                 s_tlast,       // last_elem
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,       // distance
    output logic [M_TUSER_W-1:0] m_tuser        // bad_norm, saturated
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_SQRT,
        S_FIN,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_DOT,
        PH_A,
        PH_B
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic [NORM_W-1:0]          norm_scale_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       bad_reg;
    logic                       m_tvalid_reg;
    logic [DIST_W-1:0]          dist_out_reg;
    logic                       bad_out_reg;
    logic                       sat_out_reg;

    // Datapath registers
    logic signed [ACC_W-1:0]    dot_reg;
    logic [NORM_W-1:0]          norm_a_reg;
    logic [NORM_W-1:0]          norm_b_reg;
    logic [DIV_W-1:0]           div_q_reg;
    logic [REM_W-1:0]           div_r_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;
    logic [DIV_W-1:0]           dq_reg;
    logic                       drem_nz_reg;
    logic [TERM_W-1:0]          ta_reg;
    logic [TERM_W-1:0]          tb_reg;
    logic [SQ_W-1:0]            sx_reg;
    logic [SR_W-1:0]            sr_reg;
    logic [SQ_W-1:0]            sbit_reg;
    logic signed [WIDE_W-1:0]   d_reg;

    logic signed [ELEM_W-1:0]   elem_a;
    logic signed [ELEM_W-1:0]   elem_b;
    logic signed [PROD_W-1:0]   elem_prod;
    logic signed [ACC_W-1:0]    acc_sum;
    logic                       s_accept;
    logic [NORM_W-1:0]          den;
    logic [ACC_W-1:0]           dot_mag;

    logic [REM_W-1:0]           div_shift;
    logic [REM_W-1:0]           div_r_next;
    logic [DIV_W-1:0]           div_quot;
    logic [SR_W-1:0]            sq_trial;
    logic [SUB_W-1:0]           sub_a;
    logic [SUB_W-1:0]           sub_b;
    logic [SUB_W-1:0]           sub_diff;
    logic                       sub_ge;
    logic [SQ_W-1:0]            mul_next;
    logic [DIV_W:0]             q_mag;
    logic signed [WIDE_W-1:0]   q_signed;
    logic signed [WIDE_W-1:0]   d_next;
    logic                       out_free;

    // Input unpacking and element product
    assign elem_a    = s_tdata[ELEM_W-1:0];
    assign elem_b    = s_tdata[2*ELEM_W-1:ELEM_W];
    assign elem_prod = elem_a * elem_b;
    assign acc_sum   = acc_reg + ACC_W'(elem_prod);
    assign s_accept  = s_tvalid && s_tready;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign den       = (norm_scale_reg == '0) ? NORM_W'(1) : norm_scale_reg;
    assign dot_mag   = dot_reg[ACC_W-1] ? ACC_W'(-dot_reg) : ACC_W'(dot_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Shared compare/subtract unit
    assign div_shift = {div_r_reg[REM_W-2:0], div_q_reg[DIV_W-1]};
    assign sq_trial  = sr_reg + SR_W'(sbit_reg);

    always_comb
    begin
        unique case (state_reg)
            S_DIV:
            begin
                sub_a = SUB_W'(div_shift);
                sub_b = SUB_W'(den);
            end
            S_SQRT:
            begin
                sub_a = SUB_W'(sx_reg);
                sub_b = SUB_W'(sq_trial);
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_diff   = sub_a - sub_b;
    assign sub_ge     = !sub_diff[SUB_W-1];
    assign div_r_next = sub_ge ? sub_diff[REM_W-1:0] : div_shift;
    assign div_quot   = {div_q_reg[DIV_W-2:0], sub_ge};

    // Norm term product, full 33 bits (1.0 times 1.0 needs the top bit)
    assign mul_next = SQ_W'(ta_reg) * SQ_W'(tb_reg);

    // Final sum: 1 - q - s, with q rounded toward minus infinity
    assign q_mag    = (DIV_W+1)'(dq_reg) + (DIV_W+1)'(dot_reg[ACC_W-1] && drem_nz_reg);
    assign q_signed = dot_reg[ACC_W-1] ? -WIDE_W'(q_mag) : WIDE_W'(q_mag);
    assign d_next   = WIDE_W'(ONE_Q16) - q_signed - WIDE_W'(sr_reg[TERM_W-1:0]);

    // Sequencer, control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_DOT;
            norm_scale_reg <= NORM_W'(1);
            acc_reg        <= '0;
            bad_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            dist_out_reg   <= '0;
            bad_out_reg    <= 1'b0;
            sat_out_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                norm_scale_reg <= cfg_data;
            end

            // Result taken; in S_OUT the next one is loaded below instead
            if (m_tvalid_reg && m_tready && state_reg != S_OUT)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        if (s_tlast)
                        begin
                            acc_reg   <= '0;
                            bad_reg   <= 1'b0;
                            phase_reg <= PH_DOT;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            acc_reg <= acc_sum;
                        end
                    end
                end

                // Start a division, or clamp a norm term that is out of range
                S_LOAD:
                begin
                    unique case (phase_reg)
                        PH_DOT:
                        begin
                            state_reg <= S_DIV;
                        end
                        PH_A:
                        begin
                            if (norm_a_reg > den)
                            begin
                                bad_reg   <= 1'b1;
                                phase_reg <= PH_B;
                            end
                            else
                            begin
                                state_reg <= S_DIV;
                            end
                        end
                        PH_B:
                        begin
                            if (norm_b_reg > den)
                            begin
                                bad_reg   <= 1'b1;
                                state_reg <= S_MUL;
                            end
                            else
                            begin
                                state_reg <= S_DIV;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_DIV:
                begin
                    if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1))
                    begin
                        unique case (phase_reg)
                            PH_DOT:
                            begin
                                phase_reg <= PH_A;
                                state_reg <= S_LOAD;
                            end
                            PH_A:
                            begin
                                phase_reg <= PH_B;
                                state_reg <= S_LOAD;
                            end
                            default:
                            begin
                                state_reg <= S_MUL;
                            end
                        endcase
                    end
                end

                S_MUL:
                begin
                    state_reg <= S_SQRT;
                end

                S_SQRT:
                begin
                    if (sbit_reg[0])
                    begin
                        state_reg <= S_FIN;
                    end
                end

                S_FIN:
                begin
                    state_reg <= S_OUT;
                end

                // Saturate and load the output register once it is free
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        bad_out_reg  <= bad_reg;
                        state_reg    <= S_IDLE;
                        priority if (d_reg > DIST_MAX)
                        begin
                            dist_out_reg <= DIST_POS_CODE;
                            sat_out_reg  <= 1'b1;
                        end
                        else if (d_reg < DIST_MIN)
                        begin
                            dist_out_reg <= DIST_NEG_CODE;
                            sat_out_reg  <= 1'b1;
                        end
                        else
                        begin
                            dist_out_reg <= d_reg[DIST_W-1:0];
                            sat_out_reg  <= 1'b0;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept && s_tlast)
                begin
                    dot_reg    <= acc_sum;
                    norm_a_reg <= s_tdata[2*ELEM_W+NORM_W-1:2*ELEM_W];
                    norm_b_reg <= s_tdata[2*ELEM_W+2*NORM_W-1:2*ELEM_W+NORM_W];
                    ta_reg     <= '0;
                    tb_reg     <= '0;
                end
            end

            S_LOAD:
            begin
                div_r_reg   <= '0;
                div_cnt_reg <= '0;
                unique case (phase_reg)
                    PH_DOT:  div_q_reg <= {dot_mag, FRAC_W'(0)};
                    PH_A:    div_q_reg <= DIV_W'({norm_a_reg, FRAC_W'(0)});
                    PH_B:    div_q_reg <= DIV_W'({norm_b_reg, FRAC_W'(0)});
                    default: div_q_reg <= '0;
                endcase
            end

            // One quotient bit per cycle
            S_DIV:
            begin
                div_q_reg   <= div_quot;
                div_r_reg   <= div_r_next;
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    unique case (phase_reg)
                        PH_DOT:
                        begin
                            dq_reg      <= div_quot;
                            drem_nz_reg <= (div_r_next != '0);
                        end
                        PH_A:    ta_reg <= ONE_Q16 - div_quot[TERM_W-1:0];
                        default: tb_reg <= ONE_Q16 - div_quot[TERM_W-1:0];
                    endcase
                end
            end

            S_MUL:
            begin
                sx_reg   <= mul_next;
                sr_reg   <= '0;
                sbit_reg <= {1'b1, (SQ_W-1)'(0)};
            end

            // One root bit per cycle
            S_SQRT:
            begin
                sbit_reg <= sbit_reg >> 2;
                if (sub_ge)
                begin
                    sx_reg <= sub_diff[SQ_W-1:0];
                    sr_reg <= (sr_reg >> 1) + SR_W'(sbit_reg);
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
            end

            S_FIN:
            begin
                d_reg <= d_next;
            end

            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(dist_out_reg);
    assign m_tuser  = {sat_out_reg, bad_out_reg};

endmodule

>>> sv/ipsd_checker.sv
module ipsd_checker
    import ipsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A final element starts the busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still ready after a final element");

    // Saturated results sit exactly on a limit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USER_SATURATED] |->
            m_tdata[DIST_W-1:0] == DIST_POS_CODE || m_tdata[DIST_W-1:0] == DIST_NEG_CODE)
        else $error("saturated distance not at a limit");

    // Distance never leaves plus or minus 2
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[DIST_W-1:0]) <= $signed(DIST_POS_CODE) &&
            $signed(m_tdata[DIST_W-1:0]) >= $signed(DIST_NEG_CODE))
        else $error("distance out of range");

endmodule

bind inner_product_search_distance_core ipsd_checker u_ipsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/tb.sv
module tb;
    import ipsd_pkg::*;

    localparam int IDLE_PCT        = 25;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 200;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_ITEMS     = 95;
    localparam int WRAP_LEN        = 520;   // enough max products to wrap 40 bits
    localparam int MAX_PRINTS      = 50;

    localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << 30;   // 1.0 in Q.30
    localparam logic [NORM_W-1:0] NORM_TOP = '1;
    localparam logic [ELEM_W-1:0] ELEM_MIN = 16'h8000;
    localparam logic [ELEM_W-1:0] ELEM_MAX = 16'h7fff;

    typedef struct packed {
        logic [ELEM_W-1:0] elem_a;
        logic [ELEM_W-1:0] elem_b;
        logic [NORM_W-1:0] norm_a;
        logic [NORM_W-1:0] norm_b;
        logic              last;
    } elem_pair_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              bad_norm;
        logic              saturated;
    } dist_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [NORM_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // elem_a, elem_b, norm_a, norm_b
    logic                 s_tlast   = 1'b0; // last_elem
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // distance
    logic [M_TUSER_W-1:0] m_tuser;          // bad_norm, saturated

    // Stimulus and prediction state
    elem_pair_t   pending_pairs[$];
    dist_result_t expected_dists[$];
    int           queued_count   = 0;
    int           accepted_count = 0;
    int           err_count      = 0;
    logic [ACC_W-1:0]  dot_sum         = '0;
    logic [NORM_W-1:0] norm_scale_copy = NORM_W'(1);
    logic [NORM_W-1:0] cur_scale       = NORM_W'(1);
    logic         no_idle  = 1'b0;
    logic         hold_req = 1'b0;
    logic         hold_done;
    int           hold_left;
    int           quiet_cycles = 0;

    always #4 clk = ~clk;

    inner_product_search_distance_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    task automatic report_mismatch(input string what);
        if (err_count < MAX_PRINTS)
            $display("MISMATCH at %0t: %s", $time, what);
        err_count++;
    endtask

    // Floor of the square root, built up one result bit at a time
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int k = FRAC_W; k >= 0; k--)
        begin
            cand = root | (64'd1 << k);
            if (cand * cand <= x)
                root = cand;
        end
        return root;
    endfunction

    // Distance for one finished dot product
    function automatic dist_result_t predict_distance(input logic [ACC_W-1:0] acc,
                                                      input logic [NORM_W-1:0] na,
                                                      input logic [NORM_W-1:0] nb,
                                                      input logic [NORM_W-1:0] scale);
        dist_result_t        res;
        logic [63:0]         den;
        logic [63:0]         mag;
        logic [63:0]         term_a;
        logic [63:0]         term_b;
        logic signed [63:0]  dot;
        logic signed [63:0]  quot;
        logic signed [63:0]  dist_val;
        logic                over_a;
        logic                over_b;
        den  = (scale == '0) ? 64'd1 : 64'(scale);
        dot  = {{(64 - ACC_W){acc[ACC_W-1]}}, acc};
        mag  = (dot[63] ? 64'(-dot) : 64'(dot)) << FRAC_W;
        // floored quotient: round the magnitude up when negative
        if (dot[63])
            quot = -$signed((mag + den - 64'd1) / den);
        else
            quot = $signed(mag / den);
        over_a = 64'(na) > den;
        over_b = 64'(nb) > den;
        term_a = over_a ? 64'd0 : 64'd65536 - ((64'(na) << FRAC_W) / den);
        term_b = over_b ? 64'd0 : 64'd65536 - ((64'(nb) << FRAC_W) / den);
        dist_val = 64'sd65536 - quot - $signed(floor_sqrt(term_a * term_b));
        res.bad_norm  = over_a | over_b;
        res.saturated = 1'b0;
        if (dist_val > 64'sd131072)
        begin
            dist_val      = 64'sd131072;
            res.saturated = 1'b1;
        end
        else if (dist_val < -64'sd131072)
        begin
            dist_val      = -64'sd131072;
            res.saturated = 1'b1;
        end
        res.distance = dist_val[DIST_W-1:0];
        return res;
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(7))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return '0;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Norms mostly within the scale, with edges and overflows mixed in
    function automatic logic [NORM_W-1:0] rand_norm(input logic [NORM_W-1:0] scale);
        logic [63:0] eff;
        logic [63:0] wide;
        eff  = (scale == '0) ? 64'd1 : 64'(scale);
        wide = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return '0;
            1: return NORM_W'(eff);
            2: return NORM_W'(eff + 64'd1);
            3: return NORM_W'(wide);
            4: return NORM_TOP;
            default: return NORM_W'(64'(NORM_W'(wide)) % (eff + 64'd1));
        endcase
    endfunction

    task automatic add_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                            input logic [NORM_W-1:0] na, input logic [NORM_W-1:0] nb,
                            input logic last);
        elem_pair_t p;
        p.elem_a = a;
        p.elem_b = b;
        p.norm_a = na;
        p.norm_b = nb;
        p.last   = last;
        pending_pairs.push_back(p);
        queued_count++;
    endtask

    // Well-formed vectors of random length until the phase has enough items
    task automatic add_random_vectors(input int target, input int max_len);
        int  added;
        int  len;
        bit  hot;
        logic [NORM_W-1:0] na;
        logic [NORM_W-1:0] nb;
        added = 0;
        while (added < target)
        begin
            len = ($urandom_range(15) == 0) ? $urandom_range(1, max_len)
                                            : $urandom_range(1, (max_len < 6) ? max_len : 6);
            hot = ($urandom_range(9) == 0);
            na  = rand_norm(cur_scale);
            nb  = rand_norm(cur_scale);
            for (int i = 0; i < len; i++)
            begin
                if (hot)
                    add_pair(ELEM_MIN, ELEM_MIN, rand_norm(cur_scale), rand_norm(cur_scale),
                             i == len - 1);
                else
                    add_pair(rand_elem(), rand_elem(),
                             (i == len - 1) ? na : rand_norm(cur_scale),
                             (i == len - 1) ? nb : rand_norm(cur_scale), i == len - 1);
            end
            added += len;
        end
    endtask

    task automatic write_norm_scale(input logic [NORM_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_scale = value;
    endtask

    // Wait for every request to go in and every result to come back
    task automatic drain();
        while (accepted_count != queued_count || expected_dists.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Element request driver
    always @(posedge clk or negedge rst_n)
    begin : send_proc
        elem_pair_t next_pair;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_pairs.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                next_pair = pending_pairs.pop_front();
                s_tdata   <= S_TDATA_W'({next_pair.norm_b, next_pair.norm_a,
                                         next_pair.elem_b, next_pair.elem_a});
                s_tlast   <= next_pair.last;
                s_tvalid  <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_OFF_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Track register writes and accepted element requests
    always @(posedge clk)
    begin : predict_proc
        logic signed [2*ELEM_W-1:0] prod;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                norm_scale_copy = cfg_data;
            if (s_tvalid && s_tready)
            begin
                prod    = $signed(s_tdata[ELEM_W-1:0]) * $signed(s_tdata[2*ELEM_W-1:ELEM_W]);
                dot_sum = dot_sum + {{(ACC_W - 2*ELEM_W){prod[2*ELEM_W-1]}}, prod};
                if (s_tlast)
                begin
                    expected_dists.push_back(predict_distance(
                        dot_sum,
                        s_tdata[2*ELEM_W +: NORM_W],
                        s_tdata[2*ELEM_W + NORM_W +: NORM_W],
                        norm_scale_copy));
                    dot_sum = '0;
                end
                accepted_count++;
            end
        end
    end

    // Compare each result request with the oldest expectation
    always @(posedge clk)
    begin : check_proc
        dist_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_dists.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected, distance %0d",
                                          $signed(m_tdata[DIST_W-1:0])));
            end
            else
            begin
                want = expected_dists.pop_front();
                if (m_tdata[DIST_W-1:0] !== want.distance)
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              $signed(m_tdata[DIST_W-1:0]),
                                              $signed(want.distance)));
                if (m_tuser[USER_BAD_NORM] !== want.bad_norm)
                    report_mismatch($sformatf("bad_norm %b, expected %b",
                                              m_tuser[USER_BAD_NORM], want.bad_norm));
                if (m_tuser[USER_SATURATED] !== want.saturated)
                    report_mismatch($sformatf("saturated %b, expected %b",
                                              m_tuser[USER_SATURATED], want.saturated));
            end
        end
    end

    // Watchdog on cycles without any accepted request
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Phases of stimulus
    initial
    begin
        logic [NORM_W-1:0] scales[7];
        scales[0] = NORM_ONE;
        scales[1] = '0;
        scales[2] = NORM_TOP;
        scales[3] = NORM_W'(1);
        scales[4] = NORM_W'(1) << 38;
        scales[5] = NORM_W'(1) << 28;
        scales[6] = NORM_W'({$urandom, $urandom});

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // norm scale still at its reset value
        add_random_vectors(40, 8);
        drain();

        // Directed: extremes with the norm scale at 1.0
        write_norm_scale(NORM_ONE);
        add_pair(ELEM_MIN, ELEM_MIN, '0, '0, 1'b1);
        add_pair(ELEM_MAX, ELEM_MIN, NORM_ONE, NORM_ONE, 1'b1);
        add_pair(ELEM_MAX, ELEM_MAX, NORM_ONE + 1, '0, 1'b1);
        add_pair('0, '0, '0, NORM_TOP, 1'b1);
        add_pair('0, '0, NORM_TOP, NORM_TOP, 1'b1);
        for (int i = 0; i < 4; i++)
            add_pair(ELEM_MIN, ELEM_MIN, '0, '0, i == 3);
        for (int i = 0; i < 4; i++)
            add_pair(ELEM_MIN, ELEM_MAX, '0, '0, i == 3);
        add_pair(16'sd12345, -16'sd23456, NORM_ONE >> 1, NORM_ONE >> 2, 1'b0);
        add_pair(16'h5555, 16'haaaa, 39'h2a_aaaa_aaaa, 39'h55_5555_5555, 1'b1);
        drain();

        // Random phases over several scales
        for (int p = 0; p < 7; p++)
        begin
            write_norm_scale(scales[p]);
            no_idle  <= (p == 1);
            hold_req <= (p == 3);
            if (p == 4)
            begin
                // accumulator runs past its 40-bit range and wraps
                for (int i = 0; i < WRAP_LEN; i++)
                    add_pair(ELEM_MIN, ELEM_MIN, rand_norm(cur_scale), rand_norm(cur_scale),
                             i == WRAP_LEN - 1);
            end
            add_random_vectors(PHASE_ITEMS, (p == 3) ? 2 : (p == 6) ? 300 : 40);
            drain();
        end

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> inner_product_search_distance_core.f
sv/ipsd_pkg.sv
sv/inner_product_search_distance_core.sv
sv/ipsd_checker.sv
dv/tb.sv
